// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL. They compile to nothing when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks a property at every rising clock edge outside reset.
`define STOK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define STOK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STOK_ASSERT(lbl, prop, msg)
`define STOK_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/stok_pkg.sv =====
// ----------------------------------------------------------------------------
// Source tokeniser package
// Types, widths and keyword tables shared by the tokeniser files.
// ----------------------------------------------------------------------------
`default_nettype none

package stok_pkg;

  localparam int OffsetWidth = 16;
  localparam int LineWidth   = 16;
  localparam int FieldWidth  = 16;

  localparam int NumKw    = 7;
  localparam int KwIdxW   = $clog2(NumKw);
  localparam int KwMaxLen = 13;
  localparam int KwPosW   = $clog2(KwMaxLen);

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [2:0] {
    ScanIdle   = 3'd0,
    ScanIdent  = 3'd1,
    ScanNumber = 3'd2,
    ScanDq     = 3'd3,
    ScanSq     = 3'd4,
    ScanEq     = 3'd5,
    ScanBang   = 3'd6
  } scan_mode_e;

  typedef enum logic [4:0] {
    TokIllegal    = 5'd0,
    TokEof        = 5'd1,
    TokAssign     = 5'd2,
    TokPlus       = 5'd3,
    TokMinus      = 5'd4,
    TokSlash      = 5'd5,
    TokAsterisk   = 5'd6,
    TokBang       = 5'd7,
    TokLt         = 5'd8,
    TokGt         = 5'd9,
    TokLparen     = 5'd10,
    TokRparen     = 5'd11,
    TokLbrace     = 5'd12,
    TokRbrace     = 5'd13,
    TokComma      = 5'd14,
    TokSemicolon  = 5'd15,
    TokEq         = 5'd16,
    TokNoteq      = 5'd17,
    TokInt        = 5'd18,
    TokString     = 5'd19,
    TokIdent      = 5'd20,
    TokKwVariable = 5'd21,
    TokKwProc     = 5'd22,
    TokKwRegresa  = 5'd23,
    TokKwSi       = 5'd24,
    TokKwSiNo     = 5'd25,
    TokKwVerdad   = 5'd26,
    TokKwFalso    = 5'd27
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e               kind;
    logic [FieldWidth-1:0]   line;
    logic [FieldWidth-1:0]   start;
    logic [FieldWidth-1:0]   length;
    logic                    last;
  } tok_t;

  // Keyword text, right-justified: the first character sits highest.
  localparam logic [KwMaxLen*8-1:0] KwStr [NumKw] = '{
    "variable", "procedimiento", "regresa", "si", "si_no", "verdadero", "falso"
  };
  localparam logic [KwPosW:0] KwLen [NumKw] = '{
    5'd8, 5'd13, 5'd7, 5'd2, 5'd5, 5'd9, 5'd5
  };

  // Character of keyword k at position pos; zero beyond the keyword's end.
  function automatic logic [7:0] kw_char(logic [KwIdxW-1:0] k, logic [KwPosW-1:0] pos);
    logic [KwPosW:0] sel;
    sel = KwLen[k] - 1'b1 - {1'b0, pos};
    if ({1'b0, pos} < KwLen[k]) begin
      return KwStr[k][8*sel +: 8];
    end
    return 8'h00;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/stok_if.sv =====
// ----------------------------------------------------------------------------
// Source tokeniser channels
// Valid/ready interfaces for source bytes in and tokens out.
// ----------------------------------------------------------------------------
`default_nettype none

interface stok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_source;

  modport source (output valid, output char_byte, output end_of_source, input ready);
  modport sink   (input valid, input char_byte, input end_of_source, output ready);
endinterface

interface stok_out_if;
  logic                           valid;
  logic                           ready;
  logic [4:0]                     token_kind;
  logic [stok_pkg::FieldWidth-1:0] token_line;
  logic [stok_pkg::FieldWidth-1:0] token_start;
  logic [stok_pkg::FieldWidth-1:0] token_length;
  logic                           last_result;

  modport source (output valid, output token_kind, output token_line, output token_start,
                  output token_length, output last_result, input ready);
  modport sink   (input valid, input token_kind, input token_line, input token_start,
                  input token_length, input last_result, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/source_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// Source tokeniser core
// Streams source text one byte per word and emits tokens with kind, line,
// start offset and length.
// ----------------------------------------------------------------------------
//  channel    | direction | word
//  tok_in_i   | in        | char_byte, end_of_source
//  tok_out_o  | out       | token_kind, token_line, token_start, token_length,
//             |           | last_result
//
// Each input word is scanned in the cycle it is accepted; up to two tokens go
// into a four-entry output queue, so one byte per cycle is taken while two entries are free.
// A word may yield two tokens; tok_in_i.ready
// falls while the queue has fewer than two free entries.
// After reset the scanner is idle at line one, offset zero; the queue is empty.
// An end word flushes the pending token, emits EOF and restarts the counters.
`default_nettype none

`include "assert_macros.svh"

module source_tokenizer_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  stok_in_if.sink         tok_in_i,
  stok_out_if.source      tok_out_o
);

  localparam logic [stok_pkg::OffsetWidth-1:0] OffMax = '1;
  localparam logic [stok_pkg::LineWidth-1:0]   LineMax = '1;

  function automatic logic [stok_pkg::OffsetWidth-1:0] off_inc(
      logic [stok_pkg::OffsetWidth-1:0] x);
    return (x == OffMax) ? x : x + 1'b1;
  endfunction

  function automatic logic [stok_pkg::FieldWidth-1:0] off_field(
      logic [stok_pkg::OffsetWidth-1:0] x);
    return stok_pkg::FieldWidth'(32'(x));
  endfunction

  function automatic logic [stok_pkg::FieldWidth-1:0] line_field(
      logic [stok_pkg::LineWidth-1:0] x);
    return stok_pkg::FieldWidth'(32'(x));
  endfunction

  // Scanner state.
  stok_pkg::scan_mode_e                 mode_q, mode_d;
  logic [stok_pkg::OffsetWidth-1:0]     begin_q, begin_d;
  logic [stok_pkg::OffsetWidth-1:0]     count_q, count_d;
  logic [stok_pkg::OffsetWidth-1:0]     idx_q, idx_d;
  logic [stok_pkg::LineWidth-1:0]       line_q, line_d;
  logic [stok_pkg::NumKw-1:0]           flags_q, flags_d;

  // Output queue.
  stok_pkg::tok_t                       fifo_q [stok_pkg::FifoDepth];
  logic [stok_pkg::FifoPtrW-1:0]        wr_q, rd_q;
  logic [stok_pkg::FifoCntW-1:0]        cnt_q, cnt_d;

  logic [7:0] c;
  logic       eos;
  logic       in_acc;
  logic       pop;
  logic       is_letter, is_digit;

  // Decode of a byte seen between tokens.
  stok_pkg::scan_mode_e             idle_mode;
  logic [stok_pkg::OffsetWidth-1:0] idle_begin;
  logic [stok_pkg::OffsetWidth-1:0] idle_count;
  logic                             idle_start;
  logic                             idle_emit;
  logic                             idle_nl;
  stok_pkg::tok_kind_e              idle_kind;

  logic [stok_pkg::NumKw-1:0]       flags_first, flags_hit;
  stok_pkg::tok_kind_e              ident_kind;

  logic                             restart;
  logic                             pend_v, sec_v;
  stok_pkg::tok_kind_e              pend_kind, sec_kind;
  logic [stok_pkg::FieldWidth-1:0]  pend_start, pend_len, sec_len;
  stok_pkg::tok_t                   tok_a, tok_b;
  logic [1:0]                       n_push;

  assign c      = tok_in_i.char_byte;
  assign eos    = tok_in_i.end_of_source;
  assign in_acc = tok_in_i.valid && tok_in_i.ready;
  assign pop    = tok_out_o.valid && tok_out_o.ready;

  assign is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_digit  = (c >= "0" && c <= "9");

  // Running keyword match: position 0 for a new identifier, count_q otherwise.
  always_comb begin
    for (int k = 0; k < stok_pkg::NumKw; k++) begin
      flags_first[k] = (c == stok_pkg::kw_char(stok_pkg::KwIdxW'(k), '0));
      flags_hit[k]   = (count_q < stok_pkg::OffsetWidth'(stok_pkg::KwLen[k])) &&
                       (c == stok_pkg::kw_char(stok_pkg::KwIdxW'(k),
                                               count_q[stok_pkg::KwPosW-1:0]));
    end
  end

  // The lowest-numbered keyword whose flag survives and whose length matches.
  always_comb begin
    ident_kind = stok_pkg::TokIdent;
    for (int k = stok_pkg::NumKw - 1; k >= 0; k--) begin
      if (flags_q[k] && count_q == stok_pkg::OffsetWidth'(stok_pkg::KwLen[k])) begin
        ident_kind = stok_pkg::tok_kind_e'(5'(stok_pkg::TokKwVariable) + 5'(k));
      end
    end
  end

  always_comb begin
    idle_mode  = stok_pkg::ScanIdle;
    idle_begin = idx_q;
    idle_count = '0;
    idle_start = 1'b0;
    idle_emit  = 1'b0;
    idle_nl    = 1'b0;
    idle_kind  = stok_pkg::TokIllegal;
    unique case (c)
      "\n": idle_nl = 1'b1;
      "\r", " ", "\t": ;
      "=": begin
        idle_mode  = stok_pkg::ScanEq;
        idle_start = 1'b1;
      end
      "!": begin
        idle_mode  = stok_pkg::ScanBang;
        idle_start = 1'b1;
      end
      "\"": begin
        idle_mode  = stok_pkg::ScanDq;
        idle_begin = off_inc(idx_q);
        idle_start = 1'b1;
      end
      "'": begin
        idle_mode  = stok_pkg::ScanSq;
        idle_begin = off_inc(idx_q);
        idle_start = 1'b1;
      end
      "+": begin idle_emit = 1'b1; idle_kind = stok_pkg::TokPlus;      end
      "-": begin idle_emit = 1'b1; idle_kind = stok_pkg::TokMinus;     end
      "/": begin idle_emit = 1'b1; idle_kind = stok_pkg::TokSlash;     end
      "*": begin idle_emit = 1'b1; idle_kind = stok_pkg::TokAsterisk;  end
      "<": begin idle_emit = 1'b1; idle_kind = stok_pkg::TokLt;        end
      ">": begin idle_emit = 1'b1; idle_kind = stok_pkg::TokGt;        end
      "(": begin idle_emit = 1'b1; idle_kind = stok_pkg::TokLparen;    end
      ")": begin idle_emit = 1'b1; idle_kind = stok_pkg::TokRparen;    end
      "{": begin idle_emit = 1'b1; idle_kind = stok_pkg::TokLbrace;    end
      "}": begin idle_emit = 1'b1; idle_kind = stok_pkg::TokRbrace;    end
      ",": begin idle_emit = 1'b1; idle_kind = stok_pkg::TokComma;     end
      ";": begin idle_emit = 1'b1; idle_kind = stok_pkg::TokSemicolon; end
      default: begin
        if (is_letter) begin
          idle_mode  = stok_pkg::ScanIdent;
          idle_count = stok_pkg::OffsetWidth'(1);
          idle_start = 1'b1;
        end else if (is_digit) begin
          idle_mode  = stok_pkg::ScanNumber;
          idle_count = stok_pkg::OffsetWidth'(1);
          idle_start = 1'b1;
        end else begin
          idle_emit = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    mode_d     = mode_q;
    begin_d    = begin_q;
    count_d    = count_q;
    idx_d      = off_inc(idx_q);
    line_d     = line_q;
    flags_d    = flags_q;
    restart    = 1'b0;
    pend_v     = 1'b0;
    pend_kind  = stok_pkg::TokIllegal;
    pend_start = off_field(begin_q);
    pend_len   = off_field(count_q);

    if (eos) begin
      unique case (mode_q)
        stok_pkg::ScanIdent: begin
          pend_v    = 1'b1;
          pend_kind = ident_kind;
        end
        stok_pkg::ScanNumber: begin
          pend_v    = 1'b1;
          pend_kind = stok_pkg::TokInt;
        end
        stok_pkg::ScanDq, stok_pkg::ScanSq: begin
          pend_v    = 1'b1;
          pend_kind = stok_pkg::TokString;
          pend_len  = '0;
        end
        stok_pkg::ScanEq: begin
          pend_v    = 1'b1;
          pend_kind = stok_pkg::TokAssign;
          pend_len  = stok_pkg::FieldWidth'(1);
        end
        stok_pkg::ScanBang: begin
          pend_v    = 1'b1;
          pend_kind = stok_pkg::TokBang;
          pend_len  = stok_pkg::FieldWidth'(1);
        end
        default: ;
      endcase
      mode_d  = stok_pkg::ScanIdle;
      begin_d = '0;
      count_d = '0;
      idx_d   = '0;
      line_d  = stok_pkg::LineWidth'(1);
      flags_d = '0;
    end else begin
      unique case (mode_q)
        stok_pkg::ScanIdent: begin
          if (is_letter || is_digit || c == "_") begin
            flags_d = flags_q & flags_hit;
            count_d = off_inc(count_q);
          end else begin
            pend_v    = 1'b1;
            pend_kind = ident_kind;
            restart   = 1'b1;
          end
        end
        stok_pkg::ScanNumber: begin
          if (is_digit) begin
            count_d = off_inc(count_q);
          end else begin
            pend_v    = 1'b1;
            pend_kind = stok_pkg::TokInt;
            restart   = 1'b1;
          end
        end
        stok_pkg::ScanDq, stok_pkg::ScanSq: begin
          if ((mode_q == stok_pkg::ScanDq && c == "\"") ||
              (mode_q == stok_pkg::ScanSq && c == "'")) begin
            pend_v    = 1'b1;
            pend_kind = stok_pkg::TokString;
            mode_d    = stok_pkg::ScanIdle;
          end else begin
            count_d = off_inc(count_q);
          end
        end
        stok_pkg::ScanEq, stok_pkg::ScanBang: begin
          pend_v = 1'b1;
          if (c == "=") begin
            pend_kind = (mode_q == stok_pkg::ScanEq) ? stok_pkg::TokEq : stok_pkg::TokNoteq;
            pend_len  = stok_pkg::FieldWidth'(2);
            mode_d    = stok_pkg::ScanIdle;
          end else begin
            pend_kind = (mode_q == stok_pkg::ScanEq) ? stok_pkg::TokAssign
                                                     : stok_pkg::TokBang;
            pend_len  = stok_pkg::FieldWidth'(1);
            restart   = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase

      // The byte that ended a token, or any byte between tokens, starts afresh.
      if (restart) begin
        mode_d = stok_pkg::ScanIdle;
        if (idle_start) begin
          mode_d  = idle_mode;
          begin_d = idle_begin;
          count_d = idle_count;
          if (idle_mode == stok_pkg::ScanIdent) begin
            flags_d = flags_first;
          end
        end
        if (idle_nl && line_q != LineMax) begin
          line_d = line_q + 1'b1;
        end
      end
    end
  end

  assign sec_v    = eos || (restart && idle_emit);
  assign sec_kind = eos ? stok_pkg::TokEof : idle_kind;
  assign sec_len  = eos ? '0 : stok_pkg::FieldWidth'(1);

  always_comb begin
    tok_b.kind   = sec_kind;
    tok_b.line   = line_field(line_q);
    tok_b.start  = off_field(idx_q);
    tok_b.length = sec_len;
    tok_b.last   = 1'b1;
    if (pend_v) begin
      tok_a.kind   = pend_kind;
      tok_a.line   = line_field(line_q);
      tok_a.start  = pend_start;
      tok_a.length = pend_len;
      tok_a.last   = !sec_v;
    end else begin
      tok_a = tok_b;
    end
  end

  assign n_push = in_acc ? (2'(pend_v) + 2'(sec_v)) : 2'd0;
  assign cnt_d  = cnt_q + stok_pkg::FifoCntW'(n_push) - stok_pkg::FifoCntW'(pop);

  // Two free entries are needed before a word can be taken.
  assign tok_in_i.ready = (cnt_q <= stok_pkg::FifoCntW'(stok_pkg::FifoDepth - 2));

  assign tok_out_o.valid        = (cnt_q != '0);
  assign tok_out_o.token_kind   = fifo_q[rd_q].kind;
  assign tok_out_o.token_line   = fifo_q[rd_q].line;
  assign tok_out_o.token_start  = fifo_q[rd_q].start;
  assign tok_out_o.token_length = fifo_q[rd_q].length;
  assign tok_out_o.last_result  = fifo_q[rd_q].last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stok_pkg::ScanIdle;
      begin_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
      line_q  <= stok_pkg::LineWidth'(1);
      flags_q <= '0;
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
    end else begin
      if (in_acc) begin
        mode_q  <= mode_d;
        begin_q <= begin_d;
        count_q <= count_d;
        idx_q   <= idx_d;
        line_q  <= line_d;
        flags_q <= flags_d;
      end
      wr_q  <= wr_q + stok_pkg::FifoPtrW'(n_push);
      rd_q  <= rd_q + stok_pkg::FifoPtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_q] <= tok_a;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_q + 1'b1] <= tok_b;
    end
  end

  `STOK_ASSERT(a_fifo_bound, cnt_q <= stok_pkg::FifoCntW'(stok_pkg::FifoDepth), "queue overrun")
  `STOK_ASSERT(a_line_nonzero, line_q != '0, "line counter reached zero")
  `STOK_ASSERT(a_ident_len, (mode_q != stok_pkg::ScanIdent) || (count_q != '0), "empty ident")
  `STOK_ASSERT_NEXT(a_eos_restart, in_acc && eos, mode_q == stok_pkg::ScanIdle && idx_q == '0 && line_q == stok_pkg::LineWidth'(1), "end word did not restart scanner")
  `STOK_ASSERT_NEXT(a_idx_moves, in_acc && !eos, idx_q != '0, "byte offset did not advance")

endmodule

`default_nettype wire
